// ===== sv/xdnh_pkg.sv =====
package xdnh_pkg;

    // Fixed widths of the port fields.
    localparam int ID_FIELD_W   = 64;
    localparam int SLOT_FIELD_W = 4;
    localparam int CNT_FIELD_W  = 5;

    // Command codes; the fourth code changes nothing and answers like a write.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // One command beat.
    typedef struct packed {
        logic [1:0]              command;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [ID_FIELD_W-1:0]   peer_id;
        logic                    peer_is_server;
        logic                    peer_connected;
        logic [ID_FIELD_W-1:0]   target_id;
        logic [ID_FIELD_W-1:0]   excluded_id;
        logic                    ignore_local;
    } cmd_beat_t;

    // One result beat.
    typedef struct packed {
        logic                    hop_found;
        logic [SLOT_FIELD_W-1:0] hop_slot;
        logic [ID_FIELD_W-1:0]   hop_id;
        logic [CNT_FIELD_W-1:0]  server_neighbors;
    } res_beat_t;

    // Per-slot update strobes from the top level to one cell.
    typedef struct packed {
        logic wr;
        logic clr;
    } slot_ctrl_t;

endpackage

// ===== sv/xor_distance_next_hop_table_unit.sv =====
// Channel   | Direction | Handshake          | Payload
// command   | in        | start, busy        | cmd (cmd_beat_t)
// result    | out       | res_strobe         | res (res_beat_t)
// config    | in        | cfg_we             | cfg_wdata (own id)
//
// A write or clear beat is answered in the next cycle and busy stays low, so
// such commands can follow each other in every cycle.
// A query passes a token down the row of slot cells, one cell per cycle, from
// the launch register to the result register; busy drops in the same cycle
// as the result shows.
// Reset clears all slot valid marks, the count and own id; no clearing pass.
// The receiver cannot stall; each result beat is shown for one cycle only.
module xor_distance_next_hop_table_unit
    import xdnh_pkg::*;
#(
    parameter int TABLE_SLOTS = 16,
    parameter int ID_BITS     = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cmd_beat_t             cmd,
    output logic                  res_strobe,
    output res_beat_t             res,
    input  logic                  cfg_we,
    input  logic [ID_FIELD_W-1:0] cfg_wdata
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);

    logic [ID_BITS-1:0] own_id_reg;
    logic               busy_reg;
    logic               launch_reg;
    logic [ID_BITS-1:0] target_reg;
    logic [ID_BITS-1:0] excl_reg;
    logic               ign_reg;
    logic [ID_BITS-1:0] start_best_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               res_strobe_reg;
    logic               res_strobe_next;
    res_beat_t          res_reg;
    res_beat_t          res_next;

    logic               accept;
    logic               is_query;

    slot_ctrl_t         ctrl    [TABLE_SLOTS];
    logic               inc     [TABLE_SLOTS];
    logic               dec     [TABLE_SLOTS];
    logic               tok_vld   [TABLE_SLOTS+1];
    logic               tok_found [TABLE_SLOTS+1];
    logic [SLOT_W-1:0]  tok_slot  [TABLE_SLOTS+1];
    logic [ID_BITS-1:0] tok_hid   [TABLE_SLOTS+1];
    logic               inc_any;
    logic               dec_any;

    assign accept   = start && !busy_reg;
    assign is_query = (cmd.command == CMD_QUERY);

    // Address decode for write and clear.
    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_ctrl
        assign ctrl[i].wr  = accept && (cmd.command == CMD_WRITE)
                             && (32'(cmd.slot) == i);
        assign ctrl[i].clr = accept && (cmd.command == CMD_CLEAR)
                             && (32'(cmd.slot) == i);
    end

    // Token entering the first cell.
    assign tok_vld[0]   = launch_reg;
    assign tok_found[0] = 1'b0;
    assign tok_slot[0]  = '0;
    assign tok_hid[0]   = '0;

    // Row of slot cells.
    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        xdnh_cell #(
            .ID_BITS (ID_BITS),
            .SLOT_W  (SLOT_W),
            .IDX     (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl[i]),
            .wr_id         (cmd.peer_id[ID_BITS-1:0]),
            .wr_server     (cmd.peer_is_server),
            .wr_conn       (cmd.peer_connected),
            .target        (target_reg),
            .excl          (excl_reg),
            .ign           (ign_reg),
            .start_best    (start_best_reg),
            .tok_vld_in    (tok_vld[i]),
            .tok_found_in  (tok_found[i]),
            .tok_slot_in   (tok_slot[i]),
            .tok_hid_in    (tok_hid[i]),
            .tok_vld_out   (tok_vld[i+1]),
            .tok_found_out (tok_found[i+1]),
            .tok_slot_out  (tok_slot[i+1]),
            .tok_hid_out   (tok_hid[i+1]),
            .cnt_inc       (inc[i]),
            .cnt_dec       (dec[i])
        );
    end

    // At most one cell is addressed, so the deltas are plain ORs.
    always_comb
    begin
        inc_any = 1'b0;
        dec_any = 1'b0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            inc_any = inc_any | inc[i];
            dec_any = dec_any | dec[i];
        end
    end

    assign count_next = count_reg + CNT_W'(inc_any) - CNT_W'(dec_any);

    // Result beat selection: immediate answer for updates, token for queries.
    always_comb
    begin
        res_strobe_next = 1'b0;
        res_next        = res_reg;
        if (tok_vld[TABLE_SLOTS])
        begin
            res_strobe_next           = 1'b1;
            res_next.hop_found        = tok_found[TABLE_SLOTS];
            res_next.hop_slot         = SLOT_FIELD_W'(tok_slot[TABLE_SLOTS]);
            res_next.hop_id           = ID_FIELD_W'(tok_hid[TABLE_SLOTS]);
            res_next.server_neighbors = CNT_FIELD_W'(count_reg);
        end
        else if (accept && !is_query)
        begin
            res_strobe_next           = 1'b1;
            res_next.hop_found        = 1'b0;
            res_next.hop_slot         = '0;
            res_next.hop_id           = '0;
            res_next.server_neighbors = CNT_FIELD_W'(count_next);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg     <= '0;
            busy_reg       <= 1'b0;
            launch_reg     <= 1'b0;
            count_reg      <= '0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                own_id_reg <= cfg_wdata[ID_BITS-1:0];
            end
            launch_reg     <= accept && is_query;
            count_reg      <= count_next;
            res_strobe_reg <= res_strobe_next;
            if (accept && is_query)
            begin
                busy_reg <= 1'b1;
            end
            else if (tok_vld[TABLE_SLOTS])
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Query operands and result payload.
    always_ff @(posedge clk)
    begin
        if (accept && is_query)
        begin
            target_reg     <= cmd.target_id[ID_BITS-1:0];
            excl_reg       <= cmd.excluded_id[ID_BITS-1:0];
            ign_reg        <= cmd.ignore_local;
            start_best_reg <= own_id_reg ^ cmd.target_id[ID_BITS-1:0];
        end
        res_reg <= res_next;
    end

    assign busy       = busy_reg;
    assign res_strobe = res_strobe_reg;
    assign res        = res_reg;

endmodule

// ===== sv/xdnh_cell.sv =====
module xdnh_cell
    import xdnh_pkg::*;
#(
    parameter int ID_BITS = 64,
    parameter int SLOT_W  = 4,
    parameter int IDX     = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    // Slot update
    input  slot_ctrl_t         ctrl,
    input  logic [ID_BITS-1:0] wr_id,
    input  logic               wr_server,
    input  logic               wr_conn,
    // Query operands, held steady for the whole scan
    input  logic [ID_BITS-1:0] target,
    input  logic [ID_BITS-1:0] excl,
    input  logic               ign,
    input  logic [ID_BITS-1:0] start_best,
    // Token from the previous cell
    input  logic               tok_vld_in,
    input  logic               tok_found_in,
    input  logic [SLOT_W-1:0]  tok_slot_in,
    input  logic [ID_BITS-1:0] tok_hid_in,
    // Token to the next cell
    output logic               tok_vld_out,
    output logic               tok_found_out,
    output logic [SLOT_W-1:0]  tok_slot_out,
    output logic [ID_BITS-1:0] tok_hid_out,
    // Change of the connected server count caused by this update
    output logic               cnt_inc,
    output logic               cnt_dec
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    logic               valid_reg;
    logic [ID_BITS-1:0] id_reg;
    logic               server_reg;
    logic               conn_reg;

    logic               tok_vld_reg;
    logic               tok_found_reg;
    logic [SLOT_W-1:0]  tok_slot_reg;
    logic [ID_BITS-1:0] tok_hid_reg;

    logic [ID_BITS-1:0] best;
    logic [ID_BITS-1:0] slot_dist;
    logic               eligible;
    logic               take;
    logic               contrib_old;

    // Slot contents; only the valid mark is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.wr)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctrl.clr)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            id_reg     <= wr_id;
            server_reg <= wr_server;
            conn_reg   <= wr_conn;
        end
    end

    // Count delta: compare what the slot adds to the count before and after.
    assign contrib_old = valid_reg && conn_reg && server_reg;
    assign cnt_inc     = ctrl.wr && wr_server && wr_conn && !contrib_old;
    assign cnt_dec     = contrib_old && ((ctrl.wr && !(wr_server && wr_conn)) || ctrl.clr);

    // Scan step: the best distance so far follows from the token's chosen id.
    assign best      = tok_found_in ? (tok_hid_in ^ target) : start_best;
    assign slot_dist = id_reg ^ target;
    assign eligible  = valid_reg && conn_reg && (id_reg != excl);
    assign take      = eligible && ((slot_dist < best) || (ign && !tok_found_in))
                       && (server_reg || (id_reg == target));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            tok_vld_reg <= tok_vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_found_reg <= tok_found_in || take;
        tok_slot_reg  <= take ? MY_SLOT : tok_slot_in;
        tok_hid_reg   <= take ? id_reg : tok_hid_in;
    end

    assign tok_vld_out   = tok_vld_reg;
    assign tok_found_out = tok_found_reg;
    assign tok_slot_out  = tok_slot_reg;
    assign tok_hid_out   = tok_hid_reg;

endmodule

// ===== sv/xdnh_checker.sv =====
module xdnh_checker
    import xdnh_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input cmd_beat_t             cmd,
    input logic                  res_strobe,
    input res_beat_t             res
);

    // An update beat is answered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.command != CMD_QUERY) |=> res_strobe)
    else $error("update beat without result");

    // A query beat makes the unit busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.command == CMD_QUERY) |=> busy)
    else $error("query beat did not raise busy");

    // Every result beat follows an update beat or the end of a scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |-> ($past(start && !busy && (cmd.command != CMD_QUERY))
                        || $fell(busy)))
    else $error("result beat without cause");

    // No hop reported means zero slot and id.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && !res.hop_found |-> (res.hop_slot == '0) && (res.hop_id == '0))
    else $error("empty result carries a hop");

    // The server count never exceeds the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |-> (32'(res.server_neighbors) <= TABLE_SLOTS))
    else $error("server count out of range");

endmodule

bind xor_distance_next_hop_table_unit xdnh_checker #(
    .TABLE_SLOTS (TABLE_SLOTS)
) u_xdnh_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import xdnh_pkg::*;

    localparam int SLOTS = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = SLOTS + 6;
    localparam int RANDOM_BEATS_PER_PHASE = 310;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // The block's view of the peer table, kept in step with every accepted
    // command beat. It also queues the result beats that are due.
    class next_hop_ledger;
        logic [ID_FIELD_W-1:0] own_id;
        bit                    slot_valid[SLOTS];
        logic [ID_FIELD_W-1:0] slot_id[SLOTS];
        bit                    slot_server[SLOTS];
        bit                    slot_conn[SLOTS];
        res_beat_t             pending_hops[$];
        int                    failures;
        int                    beats_seen;
        int                    queries;
        int                    hops_found;

        function new();
            own_id = '0;
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            failures = 0;
            beats_seen = 0;
            queries = 0;
            hops_found = 0;
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // Apply one accepted command and queue the result it must produce.
        function void note_command(cmd_beat_t c);
            res_beat_t             hop;
            logic [ID_FIELD_W-1:0] best;
            logic [ID_FIELD_W-1:0] hop_dist;
            logic [CNT_FIELD_W-1:0] servers;

            hop = '0;
            beats_seen++;
            case (c.command)
                CMD_WRITE:
                begin
                    slot_valid[c.slot]  = 1'b1;
                    slot_id[c.slot]     = c.peer_id;
                    slot_server[c.slot] = c.peer_is_server;
                    slot_conn[c.slot]   = c.peer_connected;
                end
                CMD_CLEAR:
                begin
                    slot_valid[c.slot] = 1'b0;
                end
                CMD_QUERY:
                begin
                    queries++;
                    best = own_id ^ c.target_id;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!slot_valid[i] || !slot_conn[i] || slot_id[i] == c.excluded_id)
                            continue;
                        hop_dist = slot_id[i] ^ c.target_id;
                        if ((hop_dist < best || (c.ignore_local && !hop.hop_found)) &&
                            (slot_server[i] || slot_id[i] == c.target_id))
                        begin
                            best = hop_dist;
                            hop.hop_found = 1'b1;
                            hop.hop_slot = i[SLOT_FIELD_W-1:0];
                            hop.hop_id = slot_id[i];
                        end
                    end
                    if (hop.hop_found)
                        hops_found++;
                end
                default: ;
            endcase

            servers = '0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_conn[i] && slot_server[i])
                    servers++;
            hop.server_neighbors = servers;
            pending_hops = {pending_hops, hop};
        endfunction

        // Compare one result beat with the oldest one due.
        function void check_result(res_beat_t got);
            res_beat_t want;

            if (pending_hops.size() == 0)
            begin
                report($sformatf("result beat with nothing due: found=%b slot=%0d id=%h srv=%0d",
                                 got.hop_found, got.hop_slot, got.hop_id,
                                 got.server_neighbors));
                return;
            end
            want = pending_hops.pop_front();
            if (got.hop_found !== want.hop_found || got.hop_slot !== want.hop_slot ||
                got.hop_id !== want.hop_id || got.server_neighbors !== want.server_neighbors)
                report($sformatf({"expected found=%b slot=%0d id=%h srv=%0d, ",
                                  "got found=%b slot=%0d id=%h srv=%0d"},
                                 want.hop_found, want.hop_slot, want.hop_id,
                                 want.server_neighbors, got.hop_found, got.hop_slot,
                                 got.hop_id, got.server_neighbors));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    cmd_beat_t             cmd = '0;
    logic                  res_strobe;
    res_beat_t             res;
    logic                  cfg_we = 1'b0;
    logic [ID_FIELD_W-1:0] cfg_wdata = '0;

    next_hop_ledger        ledger = new();
    logic [ID_FIELD_W-1:0] id_pool[8];
    int                    sender_idle_pct = 0;
    int                    stall_cycles = 0;
    int                    settings_used = 0;

    xor_distance_next_hop_table_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .res_strobe (res_strobe),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Track configuration writes, accepted command beats and result beats.
    // The same block runs the watchdog on cycles where nothing moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                ledger.own_id = cfg_wdata;
            if (start && !busy)
                ledger.note_command(cmd);
            if (res_strobe)
                ledger.check_result(res);

            if ((start && !busy) || res_strobe)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d idle cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic cmd_beat_t make_beat(logic [1:0] op, int slot_no,
                                            logic [ID_FIELD_W-1:0] peer, bit srv, bit conn,
                                            logic [ID_FIELD_W-1:0] target,
                                            logic [ID_FIELD_W-1:0] excluded, bit ign);
        cmd_beat_t b;

        b.command = op;
        b.slot = slot_no[SLOT_FIELD_W-1:0];
        b.peer_id = peer;
        b.peer_is_server = srv;
        b.peer_connected = conn;
        b.target_id = target;
        b.excluded_id = excluded;
        b.ignore_local = ign;
        return b;
    endfunction

    // Ids are drawn so that many lie close to each other, to the targets and
    // to the own id, which makes the distance comparisons matter.
    function automatic logic [ID_FIELD_W-1:0] pick_id();
        case ($urandom_range(4))
            0: return {$urandom, $urandom};
            1: return id_pool[$urandom_range(7)];
            2: return id_pool[$urandom_range(7)] ^ (64'd1 << $urandom_range(63));
            3: return ledger.own_id ^ 64'($urandom_range(255));
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    function automatic cmd_beat_t random_beat();
        cmd_beat_t b;
        int        pick;

        pick = $urandom_range(99);
        if (pick < 35)
            b.command = CMD_WRITE;
        else if (pick < 47)
            b.command = CMD_CLEAR;
        else if (pick < 95)
            b.command = CMD_QUERY;
        else
            b.command = CMD_SPARE;
        b.slot = SLOT_FIELD_W'($urandom_range(SLOTS - 1));
        b.peer_id = pick_id();
        b.peer_is_server = ($urandom_range(99) < 60);
        b.peer_connected = ($urandom_range(99) < 80);
        b.target_id = pick_id();
        b.excluded_id = ($urandom_range(2) == 0) ? {$urandom, $urandom} : pick_id();
        b.ignore_local = 1'($urandom_range(1));
        return b;
    endfunction

    // Present one command beat, with a random gap first, and return at the
    // edge where it is taken.
    task automatic send_beat(input cmd_beat_t b);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Hold off until every due result beat has come and the block is quiet.
    task automatic wait_settled();
        start <= 1'b0;
        while (ledger.pending_hops.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_own_id(input logic [ID_FIELD_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random_phase(input logic [ID_FIELD_W-1:0] own, input int idle_pct);
        wait_settled();
        write_own_id(own);
        sender_idle_pct = idle_pct;
        foreach (id_pool[i])
            id_pool[i] = (i < 3) ? (own ^ 64'($urandom_range(1023))) : {$urandom, $urandom};
        for (int n = 0; n < RANDOM_BEATS_PER_PHASE; n++)
        begin
            send_beat(random_beat());
            // Now and then let every due result beat come in mid-phase.
            if ($urandom_range(149) == 0)
                wait_settled();
        end
    endtask

    initial
    begin
        logic [ID_FIELD_W-1:0] ones;

        ones = '1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats with own id zero, so the starting distance is the
        // target itself.
        write_own_id('0);
        send_beat(make_beat(CMD_QUERY, 0, 0, 0, 0, ones, 0, 1));
        send_beat(make_beat(CMD_WRITE, 0, ones, 1, 1, 0, 0, 0));
        send_beat(make_beat(CMD_WRITE, 15, 0, 0, 1, ones, ones, 1));
        send_beat(make_beat(CMD_WRITE, 7, 64'h5, 1, 0, 0, 0, 0));
        send_beat(make_beat(CMD_WRITE, 3, 64'h10, 1, 1, 0, 0, 0));
        send_beat(make_beat(CMD_QUERY, 0, 0, 0, 0, 64'h11, ones, 0));
        send_beat(make_beat(CMD_QUERY, 0, 0, 0, 0, 0, 64'h1234, 1));
        send_beat(make_beat(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(CMD_QUERY, 0, 0, 0, 0, ones, ones, 1));
        send_beat(make_beat(CMD_SPARE, 15, ones, 1, 1, ones, ones, 1));
        send_beat(make_beat(CMD_CLEAR, 3, ones, 1, 1, ones, ones, 1));
        send_beat(make_beat(CMD_CLEAR, 7, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(CMD_QUERY, 0, 0, 0, 0, 64'h10, 0, 0));
        send_beat(make_beat(CMD_WRITE, 15, ones, 1, 1, 0, 0, 0));
        send_beat(make_beat(CMD_QUERY, 0, 0, 0, 0, ones, 0, 0));
        send_beat(make_beat(CMD_WRITE, 0, ones, 1, 0, 0, 0, 0));
        send_beat(make_beat(CMD_QUERY, 0, 0, 0, 0, ones, 0, 1));
        send_beat(make_beat(CMD_WRITE, 9, 64'h8000_0000_0000_0000, 1, 1, 0, 0, 0));
        send_beat(make_beat(CMD_QUERY, 0, 0, 0, 0, 64'h8000_0000_0000_0001, ones, 0));
        send_beat(make_beat(CMD_CLEAR, 15, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(CMD_QUERY, 0, 0, 0, 0, ones, 0, 1));

        // Random phases over several own ids and sender gap rates.
        run_random_phase(ones, 0);
        run_random_phase(ones, 53);
        run_random_phase({$urandom, $urandom}, 0);
        run_random_phase({$urandom, $urandom}, 17);

        wait_settled();
        $display("Covered %0d command beats, %0d queries (%0d with a next hop), %0d own ids.",
                 ledger.beats_seen, ledger.queries, ledger.hops_found, settings_used);
        if (ledger.pending_hops.size() != 0)
            ledger.report($sformatf("%0d result beats never came",
                                    ledger.pending_hops.size()));
        if (ledger.failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
